// ----- rtl/knnmv_pkg.sv -----
// ----------------------------------------------------------------------------
// knnmv_pkg
// Shared widths, kind codes and interface types for the nearest-neighbor
// majority vote classifier.
// ----------------------------------------------------------------------------
package knnmv_pkg;

    localparam int FEAT_W      = 16;
    localparam int CLASS_W     = 4;
    localparam int DIST_W      = 34;
    localparam int KREG_W      = 5;
    localparam int VCNT_W      = 5;
    localparam int KIND_W      = 2;
    localparam int IN_FEATURES = 4;
    localparam int MAG_W       = FEAT_W + 1;

    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

    localparam logic [KREG_W-1:0] K_RESET = 5'd3;

    typedef logic signed [FEAT_W-1:0] feat_t;
    typedef logic [CLASS_W-1:0]       class_t;
    typedef logic [DIST_W-1:0]        dist_t;

    // command to the neighbor list
    typedef struct packed {
        logic   clear;
        logic   insert;
        dist_t  key_dist;
        class_t cls;
    } topk_cmd_t;

    // outcome of one vote
    typedef struct packed {
        class_t              cls;
        logic [VCNT_W-1:0]   cnt;
        logic                empty;
    } vote_res_t;

endpackage

// ----- rtl/knnmv_sq_lane.sv -----
// ----------------------------------------------------------------------------
// knnmv_sq_lane
// One feature lane: registered difference to the query, then registered
// square of its magnitude.
// ----------------------------------------------------------------------------
module knnmv_sq_lane (
    input  logic              clk,
    input  knnmv_pkg::feat_t  feat,
    input  knnmv_pkg::feat_t  query,
    output knnmv_pkg::dist_t  sq
);
    import knnmv_pkg::*;

    logic signed [MAG_W-1:0] diff_reg;
    logic [MAG_W-1:0]        mag;
    dist_t                   sq_reg;

    assign mag = diff_reg[MAG_W-1] ? MAG_W'(-diff_reg) : MAG_W'(diff_reg);

    always_ff @(posedge clk)
    begin
        diff_reg <= MAG_W'(signed'({feat[FEAT_W-1], feat}) - signed'({query[FEAT_W-1], query}));
        sq_reg   <= DIST_W'(mag) * DIST_W'(mag);
    end

    assign sq = sq_reg;

endmodule

// ----- rtl/knnmv_topk.sv -----
// ----------------------------------------------------------------------------
// knnmv_topk
// Sorted list of the nearest neighbors. Every cell compares its own entry to
// the new key in parallel and either holds, takes the new key or takes the
// entry of the cell before it.
// ----------------------------------------------------------------------------
module knnmv_topk #(
    parameter  int K_MAX = 16,
    localparam int CNT_W = $clog2(K_MAX + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  knnmv_pkg::topk_cmd_t  cmd,
    output knnmv_pkg::class_t     list_cls [K_MAX],
    output logic [CNT_W-1:0]      held
);
    import knnmv_pkg::*;

    dist_t            dist_reg [K_MAX];
    class_t           cls_reg  [K_MAX];
    logic [CNT_W-1:0] held_reg;
    logic [CNT_W-1:0] held_next;
    logic [K_MAX-1:0] le;

    // an entry stays if held and not after the key by distance, then class
    always_comb
    begin
        for (int i = 0; i < K_MAX; i++)
        begin
            le[i] = (CNT_W'(i) < held_reg) &&
                    ((dist_reg[i] < cmd.key_dist) ||
                     ((dist_reg[i] == cmd.key_dist) && (cls_reg[i] <= cmd.cls)));
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < K_MAX; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                always_ff @(posedge clk)
                begin
                    if (cmd.insert && !le[0])
                    begin
                        dist_reg[0] <= cmd.key_dist;
                        cls_reg[0]  <= cmd.cls;
                    end
                end
            end
            else
            begin : g_body
                always_ff @(posedge clk)
                begin
                    if (cmd.insert && !le[gi])
                    begin
                        if (le[gi-1])
                        begin
                            dist_reg[gi] <= cmd.key_dist;
                            cls_reg[gi]  <= cmd.cls;
                        end
                        else
                        begin
                            dist_reg[gi] <= dist_reg[gi-1];
                            cls_reg[gi]  <= cls_reg[gi-1];
                        end
                    end
                end
            end
            assign list_cls[gi] = cls_reg[gi];
        end
    endgenerate

    always_comb
    begin
        held_next = held_reg;
        if (cmd.clear)
        begin
            held_next = '0;
        end
        else if (cmd.insert && (held_reg != CNT_W'(K_MAX)))
        begin
            held_next = held_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    assign held = held_reg;

endmodule

// ----- rtl/knnmv_vote.sv -----
// ----------------------------------------------------------------------------
// knnmv_vote
// Majority vote over the first entries of the list. Count pass: each lane
// counts how often its own class passes by on a shifting copy of the
// classes. Pick pass: lane counts shift out one a cycle into a running best.
// ----------------------------------------------------------------------------
module knnmv_vote #(
    parameter  int K_MAX = 16,
    localparam int CNT_W = $clog2(K_MAX + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [CNT_W-1:0]      vote_len,
    input  knnmv_pkg::class_t     list_cls [K_MAX],
    output logic                  done,
    output knnmv_pkg::vote_res_t  res
);
    import knnmv_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_COUNT = 2'd1;
    localparam logic [1:0] PH_PICK  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    class_t           vsh_reg  [K_MAX];
    class_t           vsh_next [K_MAX];
    logic [CNT_W-1:0] cnt_reg  [K_MAX];
    logic [CNT_W-1:0] cnt_next [K_MAX];
    logic [CNT_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] len_reg, len_next;
    class_t           best_cls_reg, best_cls_next;
    logic [CNT_W-1:0] best_cnt_reg, best_cnt_next;
    logic             empty_reg, empty_next;

    always_comb
    begin
        phase_next    = phase_reg;
        vsh_next      = vsh_reg;
        cnt_next      = cnt_reg;
        step_next     = step_reg;
        len_next      = len_reg;
        best_cls_next = best_cls_reg;
        best_cnt_next = best_cnt_reg;
        empty_next    = empty_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    best_cls_next = '0;
                    best_cnt_next = '0;
                    if (vote_len == '0)
                    begin
                        empty_next = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        empty_next = 1'b0;
                        vsh_next   = list_cls;
                        for (int j = 0; j < K_MAX; j++)
                        begin
                            cnt_next[j] = '0;
                        end
                        step_next  = '0;
                        len_next   = vote_len;
                        phase_next = PH_COUNT;
                    end
                end
            end
            PH_COUNT:
            begin
                for (int j = 0; j < K_MAX; j++)
                begin
                    if ((CNT_W'(j) < len_reg) && (list_cls[j] == vsh_reg[0]))
                    begin
                        cnt_next[j] = cnt_reg[j] + CNT_W'(1);
                    end
                end
                // shift the class copy toward lane zero
                for (int j = 0; j < K_MAX - 1; j++)
                begin
                    vsh_next[j] = vsh_reg[j+1];
                end
                if (step_reg == len_reg - CNT_W'(1))
                begin
                    vsh_next   = list_cls;
                    step_next  = '0;
                    phase_next = PH_PICK;
                end
                else
                begin
                    step_next = step_reg + CNT_W'(1);
                end
            end
            PH_PICK:
            begin
                if ((cnt_reg[0] > best_cnt_reg) ||
                    ((cnt_reg[0] == best_cnt_reg) && (vsh_reg[0] < best_cls_reg)))
                begin
                    best_cnt_next = cnt_reg[0];
                    best_cls_next = vsh_reg[0];
                end
                for (int j = 0; j < K_MAX - 1; j++)
                begin
                    vsh_next[j] = vsh_reg[j+1];
                    cnt_next[j] = cnt_reg[j+1];
                end
                if (step_reg == len_reg - CNT_W'(1))
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    step_next = step_reg + CNT_W'(1);
                end
            end
            PH_DONE:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vsh_reg      <= vsh_next;
        cnt_reg      <= cnt_next;
        step_reg     <= step_next;
        len_reg      <= len_next;
        best_cls_reg <= best_cls_next;
        best_cnt_reg <= best_cnt_next;
        empty_reg    <= empty_next;
    end

    assign done      = (phase_reg == PH_DONE);
    assign res.cls   = best_cls_reg;
    assign res.cnt   = VCNT_W'(best_cnt_reg);
    assign res.empty = empty_reg;

endmodule

// ----- rtl/knn_majority_vote_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// knn_majority_vote_classifier_unit
// Nearest-neighbor classifier: squared distance lanes, sorted neighbor list
// and a majority vote over the nearest entries.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid/in_stall  | kind, feature_0..feature_3, sample_class
//  out     | out_valid/out_stall| predicted_class, vote_count, no_samples
//  cfg     | cfg_write          | cfg_data (k_neighbors)
//
//  One word in flight. A query or an unused kind is handled as it is taken;
//  a sample passes difference, square, lane sum and list insertion. A finish
//  runs the count and pick passes of the vote over m = min(k, held) entries.
//  Reset empties the list, zeroes the query and sets k to 3. A new word is
//  taken while a result waits on out_stall, up to the next finish.
//
module knn_majority_vote_classifier_unit #(
    parameter int FEATURES    = 4,
    parameter int K_MAX       = 16,
    parameter int NUM_CLASSES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [knnmv_pkg::KIND_W-1:0]       kind,
    input  knnmv_pkg::feat_t                   feature_0,
    input  knnmv_pkg::feat_t                   feature_1,
    input  knnmv_pkg::feat_t                   feature_2,
    input  knnmv_pkg::feat_t                   feature_3,
    input  knnmv_pkg::class_t                  sample_class,
    output logic                               out_valid,
    input  logic                               out_stall,
    output knnmv_pkg::class_t                  predicted_class,
    output logic [knnmv_pkg::VCNT_W-1:0]       vote_count,
    output logic                               no_samples,
    input  logic                               cfg_write,
    input  logic [knnmv_pkg::KREG_W-1:0]       cfg_data
);
    import knnmv_pkg::*;

    localparam int CNT_W = $clog2(K_MAX + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIFF = 3'd1;
    localparam logic [2:0] ST_SQR  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_INS  = 3'd4;
    localparam logic [2:0] ST_VOTE = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [KREG_W-1:0] k_reg;
    feat_t             in_feat   [IN_FEATURES];
    feat_t             query_reg [FEATURES];
    feat_t             feat_reg  [FEATURES];
    dist_t             lane_sq   [FEATURES];
    class_t            sample_cls_reg;
    logic [DIST_W:0]   acc;
    dist_t             sum_reg;
    logic              in_accept;
    logic              cls_ok;
    topk_cmd_t         topk_cmd;
    class_t            list_cls [K_MAX];
    logic [CNT_W-1:0]  held;
    logic [CNT_W-1:0]  k_eff;
    logic [CNT_W-1:0]  vote_len;
    logic              vote_start;
    logic              vote_done;
    vote_res_t         vote_res;
    logic              out_free;
    logic              out_valid_reg;
    vote_res_t         out_reg;

    assign in_feat[0] = feature_0;
    assign in_feat[1] = feature_1;
    assign in_feat[2] = feature_2;
    assign in_feat[3] = feature_3;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cls_ok    = (int'(sample_class) < NUM_CLASSES);
    assign out_free  = !out_valid_reg || !out_stall;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= K_RESET;
        end
        else if (cfg_write)
        begin
            k_reg <= cfg_data;
        end
    end

    // query point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FEATURES; i++)
            begin
                query_reg[i] <= '0;
            end
        end
        else if (in_accept && (kind == KIND_QUERY))
        begin
            for (int i = 0; i < FEATURES; i++)
            begin
                query_reg[i] <= (i < IN_FEATURES) ? in_feat[i % IN_FEATURES] : '0;
            end
        end
    end

    // sample capture and lane sum
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < FEATURES; i++)
            begin
                feat_reg[i] <= (i < IN_FEATURES) ? in_feat[i % IN_FEATURES] : '0;
            end
            sample_cls_reg <= sample_class;
        end
        sum_reg <= acc[DIST_W-1:0];
    end

    genvar gi;
    generate
        for (gi = 0; gi < FEATURES; gi++)
        begin : g_lane
            knnmv_sq_lane u_lane (
                .clk   (clk),
                .feat  (feat_reg[gi]),
                .query (query_reg[gi]),
                .sq    (lane_sq[gi])
            );
        end
    endgenerate

    // merge the lanes, saturating at all ones
    always_comb
    begin
        acc = '0;
        for (int i = 0; i < FEATURES; i++)
        begin
            acc = acc + {1'b0, lane_sq[i]};
            if (acc[DIST_W])
            begin
                acc = {1'b0, {DIST_W{1'b1}}};
            end
        end
    end

    assign topk_cmd.clear    = in_accept && (kind == KIND_QUERY);
    assign topk_cmd.insert   = (state_reg == ST_INS);
    assign topk_cmd.key_dist = sum_reg;
    assign topk_cmd.cls      = sample_cls_reg;

    knnmv_topk #(
        .K_MAX (K_MAX)
    ) u_topk (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (topk_cmd),
        .list_cls (list_cls),
        .held     (held)
    );

    // clamp k to 1..K_MAX and to the number held
    always_comb
    begin
        if (k_reg == '0)
        begin
            k_eff = CNT_W'(1);
        end
        else if (int'(k_reg) > K_MAX)
        begin
            k_eff = CNT_W'(K_MAX);
        end
        else
        begin
            k_eff = CNT_W'(k_reg);
        end
        vote_len = (held < k_eff) ? held : k_eff;
    end

    assign vote_start = in_accept && (kind == KIND_FINISH);

    knnmv_vote #(
        .K_MAX (K_MAX)
    ) u_vote (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (vote_start),
        .vote_len (vote_len),
        .list_cls (list_cls),
        .done     (vote_done),
        .res      (vote_res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (kind)
                        KIND_SAMPLE: state_next = cls_ok ? ST_DIFF : ST_IDLE;
                        KIND_FINISH: state_next = ST_VOTE;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIFF: state_next = ST_SQR;
            ST_SQR:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_INS;
            ST_INS:  state_next = ST_IDLE;
            ST_VOTE: state_next = vote_done ? ST_OUT : ST_VOTE;
            ST_OUT:  state_next = out_free ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                // drop the word once taken
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OUT) && out_free)
        begin
            out_reg <= vote_res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign predicted_class = out_reg.cls;
    assign vote_count      = out_reg.cnt;
    assign no_samples      = out_reg.empty;

endmodule
